[hdl/c8rx_pkg.sv]
// ---------------------------------------------------------------------------
// c8rx_pkg
// Shared types, codes and helper functions of the crc-8 packet receiver.
// ---------------------------------------------------------------------------
package c8rx_pkg;

  // packet framing phase, used by both the link and the host side
  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  // origin codes carried on the result channel
  localparam logic [1:0] ORG_HOST   = 2'd0;
  localparam logic [1:0] ORG_RESEND = 2'd1;
  localparam logic [1:0] ORG_RETREQ = 2'd2;
  localparam logic [1:0] ORG_ACK    = 2'd3;

  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] RETREQ_DATA = 8'h01;
  localparam logic [7:0] RETREQ_CRC  = 8'h12;
  localparam logic [7:0] ACK_DATA    = 8'h00;
  localparam logic [7:0] ACK_CRC     = 8'h15;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;

  // reply that an accepted item leaves to be sent
  typedef enum logic [2:0] {
    RPL_NONE   = 3'd0,
    RPL_HOST   = 3'd1,
    RPL_RETREQ = 3'd2,
    RPL_RESEND = 3'd3,
    RPL_ACK    = 3'd4
  } reply_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SEND = 2'd1,
    ST_PAY  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic step;   // process the item being accepted
    logic rd;     // read the next resend payload byte
    logic emit;   // load the output register
  } c8rx_cmd_t;

  typedef struct packed {
    reply_t reply;
    logic   need_mem;
    logic   is_last;
    logic   out_free;
  } c8rx_stat_t;

  function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // bytes of the two fixed four-byte replies
  function automatic logic [7:0] fixed_byte(input logic [1:0] pos, input logic [7:0] data0,
                                            input logic [7:0] crc);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h01;
      2'd2:    b = data0;
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

[hdl/c8rx_in_if.sv]
// ---------------------------------------------------------------------------
// c8rx_in_if
// Input item channel: link or host byte with valid/ready.
// ---------------------------------------------------------------------------
interface c8rx_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_value;

  modport source (output valid, output func, output byte_value, input ready);
  modport sink (input valid, input func, input byte_value, output ready);
endinterface

[hdl/c8rx_out_if.sv]
// ---------------------------------------------------------------------------
// c8rx_out_if
// Result channel: one byte sent on the link per item.
// ---------------------------------------------------------------------------
interface c8rx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [1:0] tx_origin;

  modport source (output valid, output tx_byte, output tx_last, output tx_origin,
                  input ready);
  modport sink (input valid, input tx_byte, input tx_last, input tx_origin,
                output ready);
endinterface

[hdl/c8rx_cfg_if.sv]
// ---------------------------------------------------------------------------
// c8rx_cfg_if
// Configuration write channel for the retry limit register.
// ---------------------------------------------------------------------------
interface c8rx_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] retry_limit;

  modport source (output valid, output retry_limit, input ready);
  modport sink (input valid, input retry_limit, output ready);
endinterface

[hdl/crc8_packet_receiver_with_retransmit.sv]
// ---------------------------------------------------------------------------
// crc8_packet_receiver_with_retransmit
// CRC-8 packet receiver with stop-and-wait retransmission.
// ---------------------------------------------------------------------------
// Takes one byte per input item, from the link (func 0) or from the host
// (func 1), and sends the resulting link bytes one per result item. Link
// packets (id, len, data, crc) are checked with CRC-8 poly 0x07; a bad crc
// answers with a retransmit request, a good retransmit request resends the
// recorded host packet up to retry_limit times and then sends the give-up
// ack. Host bytes are forwarded as they arrive. Each resend payload byte
// takes one registered read of the single-port payload memory before it
// is sent. One item is in work at a time; the next is accepted once its
// last result is in the output register. Configuration writes are taken
// in any cycle.
// ---------------------------------------------------------------------------
module crc8_packet_receiver_with_retransmit #(
  parameter int MAX_DATA = 16
) (
  input logic        clk,
  input logic        rst_n,
  c8rx_in_if.sink    in_chan,
  c8rx_out_if.source out_chan,
  c8rx_cfg_if.sink   cfg_chan
);
  import c8rx_pkg::*;

  c8rx_cmd_t  cmd;
  c8rx_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  c8rx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  c8rx_datapath #(
    .MAX_DATA (MAX_DATA)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_chan.func),
    .in_byte         (in_chan.byte_value),
    .cfg_we          (cfg_chan.valid),
    .cfg_retry_limit (cfg_chan.retry_limit),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_tx_byte     (out_chan.tx_byte),
    .out_tx_last     (out_chan.tx_last),
    .out_tx_origin   (out_chan.tx_origin)
  );

endmodule

[hdl/c8rx_ctrl.sv]
// ---------------------------------------------------------------------------
// c8rx_ctrl
// Sequencer: accepts one item, then walks the datapath through its reply.
// ---------------------------------------------------------------------------
module c8rx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  c8rx_pkg::c8rx_stat_t stat,
  output c8rx_pkg::c8rx_cmd_t  cmd
);
  import c8rx_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (stat.reply == RPL_NONE) begin
          state_nxt = ST_IDLE;
        end else if (stat.need_mem) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_PAY;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PAY: begin
        // payload byte sits in the read register
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_SEND;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/c8rx_datapath.sv]
// ---------------------------------------------------------------------------
// c8rx_datapath
// Deframing state, crc check, recorded packet, payload memory and the
// output register.
// ---------------------------------------------------------------------------
module c8rx_datapath #(
  parameter int MAX_DATA = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  c8rx_pkg::c8rx_cmd_t  cmd,
  output c8rx_pkg::c8rx_stat_t stat,
  input  logic                 in_func,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_retry_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_tx_byte,
  output logic                 out_tx_last,
  output logic [1:0]           out_tx_origin
);
  import c8rx_pkg::*;

  localparam int IW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int PW = $clog2(MAX_DATA + 3);
  localparam logic [8:0] MAX9 = 9'(MAX_DATA);

  logic [3:0]  retry_limit_r, retry_limit_nxt;
  phase_t      rx_phase_r, rx_phase_nxt;
  logic [7:0]  rx_id_r, rx_id_nxt;
  logic [7:0]  rx_len_r, rx_len_nxt;
  logic [7:0]  rx_first_r, rx_first_nxt;
  logic [7:0]  rx_count_r, rx_count_nxt;
  logic [7:0]  rx_crc_r, rx_crc_nxt;
  logic [3:0]  retry_count_r, retry_count_nxt;
  logic [7:0]  prev_id_r, prev_id_nxt;
  logic [7:0]  prev_len_r, prev_len_nxt;
  logic [7:0]  prev_crc_r, prev_crc_nxt;
  logic        prev_bank_r, prev_bank_nxt;
  phase_t      host_phase_r, host_phase_nxt;
  logic [7:0]  host_id_r, host_id_nxt;
  logic [7:0]  host_len_r, host_len_nxt;
  logic [7:0]  host_first_r, host_first_nxt;
  logic [7:0]  host_count_r, host_count_nxt;
  logic        host_last_r, host_last_nxt;
  logic [7:0]  byte_r, byte_nxt;
  reply_t      reply_r, reply_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic [7:0]  rdata_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [1:0]  out_org_r;

  // two banks: one holds the recorded payload, the other stages the host packet
  logic [7:0]  pay_mem [2][MAX_DATA];
  logic        mem_we;
  logic        mem_bank;
  logic [IW-1:0] mem_idx;
  logic [7:0]  mem_wdata;
  logic [IW-1:0] rd_idx;

  logic [7:0]  crc_new;
  logic [8:0]  pos9, n9;
  logic        need_mem, is_last;
  logic [7:0]  em_byte;
  logic        em_last;
  logic [1:0]  em_org;

  assign crc_new = crc8_upd((rx_phase_r == PH_ID) ? 8'h00 : rx_crc_r, in_byte);

  // resend layout: id, len, min(len, max) payload bytes, crc
  assign pos9     = 9'(pos_r);
  assign n9       = (9'(prev_len_r) > MAX9) ? MAX9 : 9'(prev_len_r);
  assign need_mem = (reply_r == RPL_RESEND) && (pos9 >= 9'd2) && (pos9 < n9 + 9'd2);
  assign rd_idx   = IW'(pos_r - PW'(2));

  always_comb begin
    case (reply_r)
      RPL_HOST:   is_last = 1'b1;
      RPL_RETREQ: is_last = (pos_r == PW'(3));
      RPL_ACK:    is_last = (pos_r == PW'(3));
      RPL_RESEND: is_last = (pos9 == n9 + 9'd2);
      default:    is_last = 1'b0;
    endcase
  end

  always_comb begin
    em_last = is_last;
    case (reply_r)
      RPL_HOST: begin
        em_byte = byte_r;
        em_last = host_last_r;
        em_org  = ORG_HOST;
      end
      RPL_RETREQ: begin
        em_byte = fixed_byte(pos_r[1:0], RETREQ_DATA, RETREQ_CRC);
        em_org  = ORG_RETREQ;
      end
      RPL_ACK: begin
        em_byte = fixed_byte(pos_r[1:0], ACK_DATA, ACK_CRC);
        em_org  = ORG_ACK;
      end
      RPL_RESEND: begin
        em_org = ORG_RESEND;
        if (pos_r == PW'(0)) begin
          em_byte = prev_id_r;
        end else if (pos_r == PW'(1)) begin
          em_byte = prev_len_r;
        end else if (need_mem) begin
          em_byte = rdata_r;
        end else begin
          em_byte = prev_crc_r;
        end
      end
      default: begin
        em_byte = byte_r;
        em_org  = ORG_HOST;
      end
    endcase
  end

  assign stat.reply    = reply_r;
  assign stat.need_mem = need_mem;
  assign stat.is_last  = is_last;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    retry_limit_nxt = cfg_we ? cfg_retry_limit : retry_limit_r;
    rx_phase_nxt    = rx_phase_r;
    rx_id_nxt       = rx_id_r;
    rx_len_nxt      = rx_len_r;
    rx_first_nxt    = rx_first_r;
    rx_count_nxt    = rx_count_r;
    rx_crc_nxt      = rx_crc_r;
    retry_count_nxt = retry_count_r;
    prev_id_nxt     = prev_id_r;
    prev_len_nxt    = prev_len_r;
    prev_crc_nxt    = prev_crc_r;
    prev_bank_nxt   = prev_bank_r;
    host_phase_nxt  = host_phase_r;
    host_id_nxt     = host_id_r;
    host_len_nxt    = host_len_r;
    host_first_nxt  = host_first_r;
    host_count_nxt  = host_count_r;
    host_last_nxt   = host_last_r;
    byte_nxt        = byte_r;
    reply_nxt       = reply_r;
    pos_nxt         = pos_r;
    mem_we          = 1'b0;
    mem_bank        = prev_bank_r;
    mem_idx         = '0;
    mem_wdata       = 8'h00;

    if (cmd.step) begin
      reply_nxt = RPL_NONE;
      pos_nxt   = '0;
      byte_nxt  = in_byte;
      if (!in_func) begin
        case (rx_phase_r)
          PH_ID: begin
            rx_id_nxt    = in_byte;
            rx_crc_nxt   = crc_new;
            rx_phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            rx_len_nxt   = in_byte;
            rx_crc_nxt   = crc_new;
            rx_count_nxt = 8'h00;
            rx_first_nxt = 8'h00;
            rx_phase_nxt = (in_byte == 8'h00) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            if (rx_count_r == 8'h00) begin
              rx_first_nxt = in_byte;
            end
            rx_crc_nxt   = crc_new;
            rx_count_nxt = rx_count_r + 8'd1;
            if (rx_count_r + 8'd1 == rx_len_r) begin
              rx_phase_nxt = PH_CRC;
            end
          end
          default: begin
            if (in_byte != rx_crc_r) begin
              reply_nxt = RPL_RETREQ;
            end else if (rx_id_r == 8'h00 && rx_len_r == 8'h01 && rx_first_r == 8'h01) begin
              if (retry_count_r < retry_limit_r) begin
                reply_nxt       = RPL_RESEND;
                retry_count_nxt = retry_count_r + 4'd1;
              end else begin
                // give up: the ack becomes the recorded packet
                reply_nxt       = RPL_ACK;
                prev_id_nxt     = 8'h00;
                prev_len_nxt    = 8'h01;
                prev_crc_nxt    = ACK_CRC;
                mem_we          = 1'b1;
                mem_bank        = prev_bank_r;
                mem_idx         = '0;
                mem_wdata       = ACK_DATA;
                retry_count_nxt = 4'd0;
              end
            end
            rx_phase_nxt = PH_ID;
          end
        endcase
      end else begin
        reply_nxt     = RPL_HOST;
        host_last_nxt = 1'b0;
        case (host_phase_r)
          PH_ID: begin
            host_id_nxt    = in_byte;
            host_phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            host_len_nxt   = in_byte;
            host_count_nxt = 8'h00;
            host_phase_nxt = (in_byte == 8'h00) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            if ({1'b0, host_count_r} < MAX9) begin
              mem_we    = 1'b1;
              mem_bank  = !prev_bank_r;
              mem_idx   = IW'(host_count_r);
              mem_wdata = in_byte;
            end
            if (host_count_r == 8'h00) begin
              host_first_nxt = in_byte;
            end
            host_count_nxt = host_count_r + 8'd1;
            if (host_count_r + 8'd1 == host_len_r) begin
              host_phase_nxt = PH_CRC;
            end
          end
          default: begin
            host_last_nxt = 1'b1;
            // record unless too long or itself a retransmit request
            if ({1'b0, host_len_r} <= MAX9 &&
                !(host_id_r == 8'h00 && host_len_r == 8'h01 && host_first_r == 8'h01)) begin
              prev_id_nxt   = host_id_r;
              prev_len_nxt  = host_len_r;
              prev_crc_nxt  = in_byte;
              prev_bank_nxt = !prev_bank_r;
            end
            host_phase_nxt = PH_ID;
          end
        endcase
      end
    end

    if (cmd.emit) begin
      pos_nxt = pos_r + PW'(1);
      if (is_last) begin
        reply_nxt = RPL_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
      rx_phase_r    <= PH_ID;
      rx_id_r       <= 8'h00;
      rx_len_r      <= 8'h00;
      rx_first_r    <= 8'h00;
      rx_count_r    <= 8'h00;
      rx_crc_r      <= 8'h00;
      retry_count_r <= 4'd0;
      prev_id_r     <= 8'h00;
      prev_len_r    <= 8'h00;
      prev_crc_r    <= 8'h00;
      prev_bank_r   <= 1'b0;
      host_phase_r  <= PH_ID;
      host_id_r     <= 8'h00;
      host_len_r    <= 8'h00;
      host_first_r  <= 8'h00;
      host_count_r  <= 8'h00;
      host_last_r   <= 1'b0;
      byte_r        <= 8'h00;
      reply_r       <= RPL_NONE;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      retry_limit_r <= retry_limit_nxt;
      rx_phase_r    <= rx_phase_nxt;
      rx_id_r       <= rx_id_nxt;
      rx_len_r      <= rx_len_nxt;
      rx_first_r    <= rx_first_nxt;
      rx_count_r    <= rx_count_nxt;
      rx_crc_r      <= rx_crc_nxt;
      retry_count_r <= retry_count_nxt;
      prev_id_r     <= prev_id_nxt;
      prev_len_r    <= prev_len_nxt;
      prev_crc_r    <= prev_crc_nxt;
      prev_bank_r   <= prev_bank_nxt;
      host_phase_r  <= host_phase_nxt;
      host_id_r     <= host_id_nxt;
      host_len_r    <= host_len_nxt;
      host_first_r  <= host_first_nxt;
      host_count_r  <= host_count_nxt;
      host_last_r   <= host_last_nxt;
      byte_r        <= byte_nxt;
      reply_r       <= reply_nxt;
      pos_r         <= pos_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= em_byte;
      out_last_r <= em_last;
      out_org_r  <= em_org;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[mem_bank][mem_idx] <= mem_wdata;
    end
    if (cmd.rd) begin
      rdata_r <= pay_mem[prev_bank_r][rd_idx];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_tx_last   = out_last_r;
  assign out_tx_origin = out_org_r;

endmodule

[hdl/c8rx_checker.sv]
// ---------------------------------------------------------------------------
// c8rx_checker
// Port-level checks of the crc-8 packet receiver, bound to the top level.
// ---------------------------------------------------------------------------
module c8rx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       tx_last,
  input logic [1:0] tx_origin
);
  import c8rx_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(tx_last)
                                && $stable(tx_origin))
    else $error("stalled result item changed");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // no new item while a multi-byte reply is still being sent
  a_reply_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tx_last && tx_origin != ORG_HOST |-> !in_ready)
    else $error("input taken in the middle of a reply");

  a_fixed_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tx_last && (tx_origin == ORG_RETREQ || tx_origin == ORG_ACK)
    |-> tx_byte == ((tx_origin == ORG_RETREQ) ? RETREQ_CRC : ACK_CRC))
    else $error("wrong crc on fixed reply");

endmodule

bind crc8_packet_receiver_with_retransmit c8rx_checker u_c8rx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .tx_byte   (out_chan.tx_byte),
  .tx_last   (out_chan.tx_last),
  .tx_origin (out_chan.tx_origin)
);

[bench/crc8_packet_receiver_with_retransmit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc8_packet_receiver_with_retransmit_test
// Self-checking bench for the crc-8 packet receiver with retransmission.
// A short table of link and host bytes runs first, with the replies typed in
// where they are fixed. Random packet traffic follows under several retry
// limits. Each sent link byte is checked against a predictor kept in step
// with every accepted item. Both channels idle at random, and the result
// side holds off once for a long stretch so that the input backs up.
// ---------------------------------------------------------------------------
module crc8_packet_receiver_with_retransmit_test;
  import c8rx_pkg::*;

  localparam int MAX_DATA        = 16;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int SETTLE_CYCLES   = 20;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 600000;

  localparam logic FROM_LINK = 1'b0;
  localparam logic FROM_HOST = 1'b1;

  // how the expected reply of a table row is obtained
  typedef enum logic [2:0] {
    K_PRED,
    K_NONE,
    K_FWD,
    K_FWD_LAST,
    K_RETREQ,
    K_ACK,
    K_EMPTY_RESEND
  } reply_kind_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  value;
    reply_kind_t kind;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [1:0] tx_origin;
  } link_byte_t;

  logic clk;
  logic rst_n;

  c8rx_in_if  in_chan ();
  c8rx_out_if out_chan ();
  c8rx_cfg_if cfg_chan ();

  crc8_packet_receiver_with_retransmit #(
    .MAX_DATA(MAX_DATA)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // retry limit 1 is written before this table runs
  stim_row_t directed_rows [23] = '{
    '{FROM_LINK, 8'h00, K_NONE},
    '{FROM_LINK, 8'h01, K_NONE},
    '{FROM_LINK, 8'h01, K_NONE},
    '{FROM_LINK, 8'h12, K_EMPTY_RESEND},  // nothing recorded yet
    '{FROM_LINK, 8'h00, K_NONE},
    '{FROM_LINK, 8'h01, K_NONE},
    '{FROM_LINK, 8'h01, K_NONE},
    '{FROM_LINK, 8'h12, K_ACK},
    '{FROM_LINK, 8'h00, K_NONE},
    '{FROM_LINK, 8'h00, K_NONE},          // zero length, no data phase
    '{FROM_LINK, 8'hFF, K_RETREQ},
    '{FROM_HOST, 8'hFF, K_FWD},
    '{FROM_HOST, 8'h02, K_FWD},
    '{FROM_HOST, 8'h00, K_FWD},
    '{FROM_HOST, 8'hFF, K_FWD},
    '{FROM_HOST, 8'h7E, K_FWD_LAST},      // host crc passes unchecked
    '{FROM_LINK, 8'h00, K_NONE},          // link and host bytes interleaved
    '{FROM_HOST, 8'h00, K_FWD},
    '{FROM_LINK, 8'h01, K_NONE},
    '{FROM_HOST, 8'h00, K_FWD},
    '{FROM_LINK, 8'h01, K_NONE},
    '{FROM_LINK, 8'h12, K_PRED},
    '{FROM_HOST, 8'h5A, K_FWD_LAST}
  };

  // predictor state
  logic [3:0] limit_reg = RETRY_LIMIT_RST;
  phase_t     rx_ph     = PH_ID;
  logic [7:0] rx_id     = 8'h00;
  logic [7:0] rx_len    = 8'h00;
  logic [7:0] rx_first  = 8'h00;
  logic [7:0] rx_cnt    = 8'h00;
  logic [7:0] rx_crc    = 8'h00;
  logic [3:0] retries   = 4'd0;
  logic [7:0] prev_id   = 8'h00;
  logic [7:0] prev_len  = 8'h00;
  logic [7:0] prev_crc  = 8'h00;
  logic [7:0] prev_data [MAX_DATA];
  phase_t     host_ph   = PH_ID;
  logic [7:0] host_id   = 8'h00;
  logic [7:0] host_len  = 8'h00;
  logic [7:0] host_cnt  = 8'h00;
  logic [7:0] host_buf [MAX_DATA];

  link_byte_t tx_burst [$];
  link_byte_t pending_tx [$];
  logic [7:0] link_q [$];
  logic [7:0] host_q [$];

  int   failures     = 0;
  int   cycle_count  = 0;
  int   sink_wait    = 0;
  bit   result_taken = 1'b0;
  bit   hold_req     = 1'b0;
  bit   calm         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("crc8_packet_receiver_with_retransmit regression: fail");
    $finish;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void push_tx(input logic [7:0] b, input logic last,
                                  input logic [1:0] org);
    tx_burst.push_back('{tx_byte: b, tx_last: last, tx_origin: org});
  endfunction

  function automatic void push_fixed(input logic [7:0] data0, input logic [7:0] crc,
                                     input logic [1:0] org);
    push_tx(8'h00, 1'b0, org);
    push_tx(8'h01, 1'b0, org);
    push_tx(data0, 1'b0, org);
    push_tx(crc, 1'b1, org);
  endfunction

  // link bytes that one accepted item makes the block send
  function automatic void compute_link_tx(input logic func, input logic [7:0] b);
    tx_burst.delete();
    if (func == FROM_LINK) begin
      case (rx_ph)
        PH_ID: begin
          rx_id  = b;
          rx_crc = crc8_step(8'h00, b);
          rx_ph  = PH_LEN;
        end
        PH_LEN: begin
          rx_len   = b;
          rx_crc   = crc8_step(rx_crc, b);
          rx_cnt   = 8'h00;
          rx_first = 8'h00;
          rx_ph    = (b == 8'h00) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          if (rx_cnt == 8'h00) rx_first = b;
          rx_crc = crc8_step(rx_crc, b);
          rx_cnt = rx_cnt + 8'd1;
          if (rx_cnt == rx_len) rx_ph = PH_CRC;
        end
        default: begin
          if (b != rx_crc) begin
            push_fixed(RETREQ_DATA, RETREQ_CRC, ORG_RETREQ);
          end else if (rx_id == 8'h00 && rx_len == 8'h01 && rx_first == RETREQ_DATA) begin
            if (retries < limit_reg) begin
              push_tx(prev_id, 1'b0, ORG_RESEND);
              push_tx(prev_len, 1'b0, ORG_RESEND);
              for (int i = 0; i < prev_len && i < MAX_DATA; i++)
                push_tx(prev_data[i], 1'b0, ORG_RESEND);
              push_tx(prev_crc, 1'b1, ORG_RESEND);
              retries = retries + 4'd1;
            end else begin
              push_fixed(ACK_DATA, ACK_CRC, ORG_ACK);
              prev_id      = 8'h00;
              prev_len     = 8'h01;
              prev_crc     = ACK_CRC;
              prev_data[0] = ACK_DATA;
              retries      = 4'd0;
            end
          end
          rx_ph = PH_ID;
        end
      endcase
    end else begin
      case (host_ph)
        PH_ID: begin
          host_id = b;
          push_tx(b, 1'b0, ORG_HOST);
          host_ph = PH_LEN;
        end
        PH_LEN: begin
          host_len = b;
          host_cnt = 8'h00;
          push_tx(b, 1'b0, ORG_HOST);
          host_ph = (b == 8'h00) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          if (host_cnt < MAX_DATA) host_buf[host_cnt] = b;
          host_cnt = host_cnt + 8'd1;
          push_tx(b, 1'b0, ORG_HOST);
          if (host_cnt == host_len) host_ph = PH_CRC;
        end
        default: begin
          push_tx(b, 1'b1, ORG_HOST);
          // a host retransmit request or an oversized packet is not recorded
          if (host_len <= MAX_DATA &&
              !(host_id == 8'h00 && host_len == 8'h01 && host_buf[0] == RETREQ_DATA)) begin
            prev_id  = host_id;
            prev_len = host_len;
            prev_crc = b;
            for (int i = 0; i < host_len; i++) prev_data[i] = host_buf[i];
          end
          host_ph = PH_ID;
        end
      endcase
    end
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 4));
    if (r < 88) return 8'($urandom_range(5, 16));
    if (r < 98) return 8'($urandom_range(17, 40));
    return 8'($urandom_range(41, 255));
  endfunction

  task automatic offer_item(input logic func, input logic [7:0] value,
                            input reply_kind_t kind);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.func       <= func;
    in_chan.byte_value <= value;
    do @(posedge clk); while (!in_chan.ready);
    compute_link_tx(func, value);
    if (kind != K_PRED) begin
      tx_burst.delete();
      case (kind)
        K_FWD:          push_tx(value, 1'b0, ORG_HOST);
        K_FWD_LAST:     push_tx(value, 1'b1, ORG_HOST);
        K_RETREQ:       push_fixed(RETREQ_DATA, RETREQ_CRC, ORG_RETREQ);
        K_ACK:          push_fixed(ACK_DATA, ACK_CRC, ORG_ACK);
        K_EMPTY_RESEND: begin
          push_tx(8'h00, 1'b0, ORG_RESEND);
          push_tx(8'h00, 1'b0, ORG_RESEND);
          push_tx(8'h00, 1'b1, ORG_RESEND);
        end
        default: ;
      endcase
    end
    foreach (tx_burst[i]) pending_tx.push_back(tx_burst[i]);
  endtask

  // next byte of the random traffic: mostly whole packets, some noise
  task automatic random_item();
    int         pick;
    logic       side;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] d;
    logic [7:0] crc;
    if ($urandom_range(0, 99) < 3) begin
      offer_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), K_PRED);
      return;
    end
    if (link_q.size() == 0) begin
      // after noise, finish the broken packet before starting a clean one
      if (rx_ph != PH_ID) begin
        link_q.push_back(rx_ph == PH_LEN ? 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          link_q = '{8'h00, 8'h01, RETREQ_DATA, RETREQ_CRC};
        end else if (pick < 45) begin
          link_q = '{8'h00, 8'h01, ACK_DATA, ACK_CRC};
        end else begin
          // near misses of a retransmit request, then general packets
          if (pick < 60) begin
            id  = 8'($urandom_range(0, 1));
            len = 8'($urandom_range(1, 2));
          end else begin
            id  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            len = pick_length();
          end
          crc = crc8_step(crc8_step(8'h00, id), len);
          link_q.push_back(id);
          link_q.push_back(len);
          for (int i = 0; i < len; i++) begin
            d = (pick < 60 && i == 0) ? 8'($urandom_range(0, 2))
                                      : 8'($urandom_range(0, 255));
            crc = crc8_step(crc, d);
            link_q.push_back(d);
          end
          if (pick >= 85) crc = crc ^ 8'($urandom_range(1, 255));
          link_q.push_back(crc);
        end
      end
    end
    if (host_q.size() == 0) begin
      if (host_ph != PH_ID) begin
        host_q.push_back(host_ph == PH_LEN ? 8'($urandom_range(0, 3))
                                           : 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 99) < 20) begin
        host_q = '{8'h00, 8'h01, RETREQ_DATA,
                   $urandom_range(0, 1) ? RETREQ_CRC : 8'($urandom_range(0, 255))};
      end else begin
        id  = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom_range(0, 255));
        len = pick_length();
        host_q.push_back(id);
        host_q.push_back(len);
        for (int i = 0; i < len; i++) host_q.push_back(8'($urandom_range(0, 255)));
        host_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    side = 1'($urandom_range(0, 1));
    if (side == FROM_LINK) offer_item(FROM_LINK, link_q.pop_front(), K_PRED);
    else                   offer_item(FROM_HOST, host_q.pop_front(), K_PRED);
  endtask

  task automatic write_retry_limit(input logic [3:0] lim);
    @(negedge clk);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.retry_limit <= lim;
    do @(posedge clk); while (!cfg_chan.ready);
    limit_reg = lim;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // stop offering, let every expected byte arrive, then let the block go quiet
  task automatic settle_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : tx_check
    link_byte_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_taken = 1'b1;
      if (pending_tx.size() == 0) begin
        $error("unexpected item: tx_byte %02h tx_last %0d tx_origin %0d",
               out_chan.tx_byte, out_chan.tx_last, out_chan.tx_origin);
        failures++;
      end else begin
        want = pending_tx.pop_front();
        if (out_chan.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, out_chan.tx_byte);
          failures++;
        end
        if (out_chan.tx_last !== want.tx_last) begin
          $error("tx_last: expected %0d, got %0d", want.tx_last, out_chan.tx_last);
          failures++;
        end
        if (out_chan.tx_origin !== want.tx_origin) begin
          $error("tx_origin: expected %0d, got %0d", want.tx_origin, out_chan.tx_origin);
          failures++;
        end
      end
    end
  end

  // result side: random stall after each item, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      sink_wait = LONG_HOLD;
      hold_req  = 1'b0;
    end else if (result_taken) begin
      sink_wait = calm ? 0 : $urandom_range(0, 10);
    end
    result_taken = 1'b0;
    if (sink_wait > 0) begin
      out_chan.ready <= 1'b0;
      sink_wait--;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  initial begin
    logic [3:0] phase_limit [4];
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.func         = FROM_LINK;
    in_chan.byte_value   = 8'h00;
    out_chan.ready       = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.retry_limit = 4'd0;
    for (int i = 0; i < MAX_DATA; i++) begin
      prev_data[i] = 8'h00;
      host_buf[i]  = 8'h00;
    end
    phase_limit = '{4'd15, 4'd0, RETRY_LIMIT_RST, 4'($urandom_range(1, 14))};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_retry_limit(4'd1);
    foreach (directed_rows[r])
      offer_item(directed_rows[r].func, directed_rows[r].value, directed_rows[r].kind);

    for (int p = 0; p < 4; p++) begin
      settle_idle();
      write_retry_limit(phase_limit[p]);
      // first phase resends a lot: good time to back the block up
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 24 == 0) calm = ($urandom_range(0, 3) == 0);
        random_item();
      end
    end

    settle_idle();
    if (failures == 0)
      $display("crc8_packet_receiver_with_retransmit regression: pass");
    else
      $display("crc8_packet_receiver_with_retransmit regression: fail");
    $finish;
  end

endmodule
